// File: hw/rtl/gauss_reduce_row_5tap_defines.svh
// ----------------------------------------------------------------------------
// gauss_reduce_row_5tap_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef GAUSS_REDUCE_ROW_5TAP_DEFINES_SVH
`define GAUSS_REDUCE_ROW_5TAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GR5_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GR5_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/gr5_pkg.sv
// ----------------------------------------------------------------------------
// gr5_pkg
// shared types and constants of the 5-tap row reduce block
// ----------------------------------------------------------------------------
package gr5_pkg;

	localparam int PIX_W       = 8;
	localparam int ROW_WIDTH_W = 13;
	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd640;

	// kernel sum: a + e + 5(b + d) + 8c + 10, at most 5110
	localparam int SUM_W = 13;
	localparam logic [SUM_W-1:0] SUM_RND = 13'd10;

	// divide by 20 as (sum >> 2) * ceil(2^16 / 5) >> 16
	localparam int QIN_W   = SUM_W - 2;
	localparam int RECIP_W = 14;
	localparam logic [RECIP_W-1:0] RECIP_5 = 14'd13108;
	localparam int RECIP_SH = 16;
	localparam int PROD_W   = QIN_W + RECIP_W;

	// result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;
	localparam int TAPS      = 4;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             row_end;
		logic             last;
	} res_t;

	typedef struct packed {
		logic vld;
		res_t res;
	} push_t;

endpackage

// File: hw/rtl/gr5_pix_if.sv
// ----------------------------------------------------------------------------
// gr5_pix_if
// source pixel channel, valid/ready
// ----------------------------------------------------------------------------
interface gr5_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

// File: hw/rtl/gr5_res_if.sv
// ----------------------------------------------------------------------------
// gr5_res_if
// reduced pixel channel, valid/ready
// ----------------------------------------------------------------------------
interface gr5_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_pixel;
	logic       row_end;
	logic       last;

	modport source (output valid, output out_pixel, output row_end, output last,
		input ready);
	modport sink (input valid, input out_pixel, input row_end, input last,
		output ready);
endinterface

// File: hw/rtl/gr5_tap_cell.sv
// ----------------------------------------------------------------------------
// gr5_tap_cell
// one pixel of the row window, shifts to its neighbor on each transaction
// ----------------------------------------------------------------------------
module gr5_tap_cell (
	input  logic                    clk,
	input  logic                    en,
	input  logic [gr5_pkg::PIX_W-1:0] d,
	output logic [gr5_pkg::PIX_W-1:0] q
);
	import gr5_pkg::*;

	logic [PIX_W-1:0] pix_q;

	always_ff @(posedge clk) begin
		if (en) begin
			pix_q <= d;
		end
	end

	assign q = pix_q;
endmodule

// File: hw/rtl/gr5_div20.sv
// ----------------------------------------------------------------------------
// gr5_div20
// kernel sum divided by 20 through a reciprocal multiply
// ----------------------------------------------------------------------------
module gr5_div20 (
	input  logic [gr5_pkg::SUM_W-1:0] sum,
	output logic [gr5_pkg::PIX_W-1:0] quo
);
	import gr5_pkg::*;

	logic [QIN_W-1:0]  quarter;
	logic [PROD_W-1:0] prod;

	assign quarter = sum[SUM_W-1:2];
	assign prod    = PROD_W'(quarter) * PROD_W'(RECIP_5);
	assign quo     = prod[RECIP_SH +: PIX_W];
endmodule

// File: hw/rtl/gr5_res_fifo.sv
// ----------------------------------------------------------------------------
// gr5_res_fifo
// small result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
module gr5_res_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gr5_pkg::push_t              push_a,
	input  gr5_pkg::push_t              push_b,
	input  logic                        pop,
	output gr5_pkg::res_t               head,
	output logic [gr5_pkg::RES_CNT_W-1:0] count
);
	import gr5_pkg::*;

	res_t                 mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_q;
	logic [RES_PTR_W-1:0] rd_q;
	logic [RES_CNT_W-1:0] count_q;
	logic [1:0]           n_push;

	assign n_push = {1'b0, push_a.vld} + {1'b0, push_b.vld};

	always_ff @(posedge clk) begin
		if (push_a.vld) begin
			mem[wr_q] <= push_a.res;
		end
		if (push_b.vld) begin
			mem[wr_q + RES_PTR_W'(push_a.vld)] <= push_b.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(n_push);
			rd_q    <= rd_q + RES_PTR_W'(pop);
			count_q <= count_q + RES_CNT_W'(n_push) - RES_CNT_W'(pop);
		end
	end

	assign head  = mem[rd_q];
	assign count = count_q;
endmodule

// File: hw/rtl/gauss_reduce_row_5tap.sv
// ----------------------------------------------------------------------------
// gauss_reduce_row_5tap
// halves a pixel row in x with the 1-5-8-5-1 kernel
// ----------------------------------------------------------------------------
// Takes one pixel per clock if ready. Pixel 0 of each row is copied out, each
// even centre from 2 up to two columns before the last even column of the row
// (row_width - 1 rounded down to even) is smoothed with round-half-up division
// by 20, and that last even column is copied out after it with row_end set.
// The window cells and kernel sum are registered once; the results of a pixel
// pass the reciprocal multiply and enter the four-entry queue at the edge after
// the pixel is accepted, and can be taken at the edge after that. The queue
// head drives the result channel, and pixels are refused while queued plus
// pending results exceed two. With results taken every cycle, the pixel after
// the first pixel of a row that follows a two-result row end is refused for
// one cycle, so odd row widths of 5 or more stall the input once per row.
// row_width is clamped to 3..MAX_WIDTH and should be written while idle.
// ----------------------------------------------------------------------------
module gauss_reduce_row_5tap #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gr5_pkg::ROW_WIDTH_W-1:0] cfg_wr_data,
	gr5_pix_if.sink                         pixels,
	gr5_res_if.source                       results
);
	import gr5_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;
	localparam logic [XW-1:0] MAXW_X = XW'(MAX_WIDTH);
	localparam logic [XW-1:0] MINW_X = XW'(3);

	logic [ROW_WIDTH_W-1:0] row_width_q;
	logic [WW-1:0]          column_q;
	logic [XW-1:0]          rw_x;
	logic [XW-1:0]          eff_x;
	logic [WW-1:0]          width;
	logic [WW-1:0]          width_m1;
	logic [WW-1:0]          last_col;
	logic [WW-1:0]          col;
	logic [WW-1:0]          col_inc;
	logic                   accept;
	logic                   is_first;
	logic                   is_smooth;
	logic                   is_end;

	logic [PIX_W-1:0]       tap [TAPS];
	logic [SUM_W-1:0]       bd_sum;
	logic [SUM_W-1:0]       k_sum;

	logic [SUM_W-1:0]       sum_s1;
	logic [PIX_W-1:0]       pix_s1;
	logic                   has_a_s1;
	logic                   smooth_s1;
	logic                   has_end_s1;
	logic [PIX_W-1:0]       quo;

	push_t                  push_a;
	push_t                  push_b;
	res_t                   head;
	logic [RES_CNT_W-1:0]   count;
	logic [RES_CNT_W-1:0]   pending;

	// width clamp and column decode
	assign rw_x     = XW'(row_width_q);
	assign eff_x    = (rw_x < MINW_X) ? MINW_X : ((rw_x > MAXW_X) ? MAXW_X : rw_x);
	assign width    = eff_x[WW-1:0];
	assign width_m1 = width - WW'(1);
	assign last_col = {width_m1[WW-1:1], 1'b0};
	assign col      = (column_q >= width) ? '0 : column_q;
	assign col_inc  = col + WW'(1);

	assign is_first  = (col == '0);
	assign is_smooth = (XW'(col) >= XW'(4)) && !col[0] && (col <= last_col);
	assign is_end    = (col == last_col);

	assign accept = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_RST;
		end else if (cfg_wr_en) begin
			row_width_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (accept) begin
			column_q <= (col_inc >= width) ? '0 : col_inc;
		end
	end

	// window cells, tap[0] newest
	for (genvar i = 0; i < TAPS; i++) begin : g_tap
		gr5_tap_cell u_cell (
			.clk (clk),
			.en  (accept),
			.d   ((i == 0) ? pixels.pixel : tap[(i == 0) ? 0 : i - 1]),
			.q   (tap[i])
		);
	end

	assign bd_sum = SUM_W'(tap[2]) + SUM_W'(tap[0]);
	assign k_sum  = SUM_W'(tap[3]) + SUM_W'(pixels.pixel) + (bd_sum << 2) + bd_sum
		+ (SUM_W'(tap[1]) << 3) + SUM_RND;

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1    <= k_sum;
			pix_s1    <= pixels.pixel;
			smooth_s1 <= is_smooth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_a_s1   <= 1'b0;
			has_end_s1 <= 1'b0;
		end else begin
			has_a_s1   <= accept && (is_first || is_smooth);
			has_end_s1 <= accept && is_end;
		end
	end

	gr5_div20 u_div (
		.sum (sum_s1),
		.quo (quo)
	);

	// first and second result of the pixel in stage one
	always_comb begin
		push_a.vld = has_a_s1 || has_end_s1;
		if (has_a_s1) begin
			push_a.res.out_pixel = smooth_s1 ? quo : pix_s1;
			push_a.res.row_end   = 1'b0;
			push_a.res.last      = !has_end_s1;
		end else begin
			push_a.res.out_pixel = pix_s1;
			push_a.res.row_end   = 1'b1;
			push_a.res.last      = 1'b1;
		end
		push_b.vld           = has_a_s1 && has_end_s1;
		push_b.res.out_pixel = pix_s1;
		push_b.res.row_end   = 1'b1;
		push_b.res.last      = 1'b1;
	end

	gr5_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (push_a),
		.push_b (push_b),
		.pop    (results.valid && results.ready),
		.head   (head),
		.count  (count)
	);

	assign pending       = count + RES_CNT_W'(has_a_s1) + RES_CNT_W'(has_end_s1);
	assign pixels.ready  = (pending <= RES_CNT_W'(RES_DEPTH - 2));

	assign results.valid     = (count != '0);
	assign results.out_pixel = head.out_pixel;
	assign results.row_end   = head.row_end;
	assign results.last      = head.last;
endmodule

// File: hw/rtl/gr5_checker.sv
// ----------------------------------------------------------------------------
// gr5_checker
// port-level checks of the row reduce block
// ----------------------------------------------------------------------------
`include "gauss_reduce_row_5tap_defines.svh"

module gr5_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_pixel,
	input logic       row_end,
	input logic       last
);
	import gr5_pkg::*;

	// a stalled result holds
	`GR5_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(row_end) && $stable(last), "stalled result changed")

	// the row end copy closes its pixel's transactions
	`GR5_ASSERT_NOW(a_row_end_last, out_valid && row_end, last, "row_end without last")

	// nothing queued means room for a pixel
	`GR5_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "empty queue refused a pixel")

	// backpressure is released only by a result transaction
	`GR5_ASSERT_NEXT(a_stall_holds, !in_ready && !(out_valid && out_ready), !in_ready, "stall released without a result transaction")
endmodule

bind gauss_reduce_row_5tap gr5_checker u_gr5_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_pixel (results.out_pixel),
	.row_end   (results.row_end),
	.last      (results.last)
);

// File: test/tb_gauss_reduce_row_5tap.sv
// ----------------------------------------------------------------------------
// tb_gauss_reduce_row_5tap
// self-checking bench for the 5-tap row reduce block
// ----------------------------------------------------------------------------
// Streams pixels through the valid/ready channels and checks every reduced
// pixel against an in-bench model of the row reduce: copy of column 0,
// 1-5-8-5-1 smoothing of the even centres, copy of the last even column.
// A short table of directed pixels runs first, some with hand-typed results.
// Then come random phases over row widths inside and outside the legal
// range, with sender gaps, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_gauss_reduce_row_5tap;
	import gr5_pkg::*;

	localparam int MAX_W        = 4096;
	localparam int KEEP_W       = -1;
	localparam int PREDICT      = -1;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int REPORT_MAX   = 10;

	typedef struct {
		int               w;
		logic [PIX_W-1:0] px;
		int               n;
		res_t             r0;
		res_t             r1;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [ROW_WIDTH_W-1:0] cfg_wr_data;

	gr5_pix_if pix_ch();
	gr5_res_if res_ch();

	gauss_reduce_row_5tap #(
		.MAX_WIDTH(MAX_W)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.pixels     (pix_ch),
		.results    (res_ch)
	);

	// reduce model state
	logic [ROW_WIDTH_W-1:0] width_reg = ROW_WIDTH_RST;
	int unsigned            col_pos = 0;
	logic [PIX_W-1:0]       taps[TAPS] = '{default: '0};

	res_t     reduced_q[$];
	dir_row_t dir_rows[$];

	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_req = 0;
	int  mismatches = 0;
	int  n_in = 0;
	int  n_out = 0;
	int  n_cfg = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic res_t pix_res(logic [PIX_W-1:0] px, logic re, logic la);
		return {px, re, la};
	endfunction

	function automatic int reduce_pixel(input logic [PIX_W-1:0] px, output res_t r0,
		output res_t r1);
		int unsigned w, nx2, lastc, c, sum;
		int          n;
		res_t        o[2];
		o = '{default: '0};
		n = 0;
		w = 32'(width_reg);
		if (w < 3) w = 3;
		if (w > MAX_W) w = MAX_W;
		nx2 = (w - 3) / 2;
		lastc = 2 + 2 * nx2;
		c = (col_pos >= w) ? 0 : col_pos;
		if (c == 0) begin
			o[n] = {px, 2'b00};
			n++;
		end else if (c >= 4 && c % 2 == 0 && c <= lastc) begin
			sum = taps[3] + px + 5 * (taps[2] + taps[0]) + 8 * taps[1] + 10;
			o[n] = {8'(sum / 20), 2'b00};
			n++;
		end
		if (c == lastc) begin
			o[n] = {px, 2'b10};
			n++;
		end
		if (n > 0) o[n-1].last = 1'b1;
		taps[3] = taps[2];
		taps[2] = taps[1];
		taps[1] = taps[0];
		taps[0] = px;
		c++;
		col_pos = (c >= w) ? 0 : c;
		r0 = o[0];
		r1 = o[1];
		return n;
	endfunction

	function automatic void add_row(int w, logic [PIX_W-1:0] px, int n = PREDICT,
		res_t r0 = '0, res_t r1 = '0);
		dir_rows.push_back('{w, px, n, r0, r1});
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px, input int n_typed,
		input res_t t0, input res_t t1);
		res_t p0, p1;
		int   n;
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		do @(posedge clk); while (!pix_ch.ready);
		n = reduce_pixel(px, p0, p1);
		if (n_typed != PREDICT) begin
			n = n_typed;
			p0 = t0;
			p1 = t1;
		end
		if (n > 0) reduced_q.push_back(p0);
		if (n > 1) reduced_q.push_back(p1);
		n_in++;
		if ($urandom_range(99) < idle_pct) begin
			pix_ch.valid <= 1'b0;
			pix_ch.pixel <= 8'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic set_width(input logic [ROW_WIDTH_W-1:0] w);
		pix_ch.valid <= 1'b0;
		while (reduced_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		width_reg = w;
		n_cfg++;
	endtask

	// result sink with random stalls and one long hold
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		res_t got, want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.out_pixel, res_ch.row_end, res_ch.last};
			n_out++;
			if (reduced_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected transaction: pixel %0d row_end %0b last %0b",
						got.out_pixel, got.row_end, got.last);
			end else begin
				want = reduced_q.pop_front();
				if (got.out_pixel !== want.out_pixel || got.row_end !== want.row_end ||
					got.last !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: exp pixel %0d row_end %0b last %0b, got %0d %0b %0b",
							want.out_pixel, want.row_end, want.last,
							got.out_pixel, got.row_end, got.last);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_gauss_reduce_row_5tap: errors");
		$finish;
	end

	initial begin : stimulus
		logic [ROW_WIDTH_W-1:0] phase_w[PHASES];
		logic [PIX_W-1:0]       px;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;

		// reset width 640: first copy, then a plain smoothed centre
		add_row(KEEP_W, 8'd255, 1, pix_res(8'd255, 1'b0, 1'b1));
		add_row(KEEP_W, 8'd0);
		add_row(KEEP_W, 8'd255);
		add_row(KEEP_W, 8'd0);
		add_row(KEEP_W, 8'd255, 1, pix_res(8'd128, 1'b0, 1'b1));
		// width 0 clamps to 3, mid-row change restarts the row
		add_row(0, 8'd7, 1, pix_res(8'd7, 1'b0, 1'b1));
		add_row(KEEP_W, 8'd9, 0);
		add_row(KEEP_W, 8'd200, 1, pix_res(8'd200, 1'b1, 1'b1));
		// width 5, all ones: smoothed plus row end copy on one pixel
		add_row(5, 8'd255, 1, pix_res(8'd255, 1'b0, 1'b1));
		add_row(KEEP_W, 8'd255);
		add_row(KEEP_W, 8'd255);
		add_row(KEEP_W, 8'd255);
		add_row(KEEP_W, 8'd255, 2, pix_res(8'd255, 1'b0, 1'b0), pix_res(8'd255, 1'b1, 1'b1));
		// width 6: exact rounding tie, trailing pixel ignored
		add_row(6, 8'd10, 1, pix_res(8'd10, 1'b0, 1'b1));
		add_row(KEEP_W, 8'd0);
		add_row(KEEP_W, 8'd0);
		add_row(KEEP_W, 8'd0);
		add_row(KEEP_W, 8'd0, 2, pix_res(8'd1, 1'b0, 1'b0), pix_res(8'd0, 1'b1, 1'b1));
		add_row(KEEP_W, 8'd99, 0);
		// register maximum clamps to MAX_WIDTH
		add_row(8191, 8'd128, 1, pix_res(8'd128, 1'b0, 1'b1));
		add_row(KEEP_W, 8'd1);
		add_row(KEEP_W, 8'd2);
		add_row(KEEP_W, 8'd4);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].w != KEEP_W) set_width(ROW_WIDTH_W'(dir_rows[i].w));
			send_pixel(dir_rows[i].px, dir_rows[i].n, dir_rows[i].r0, dir_rows[i].r1);
		end

		phase_w[0] = 13'd8191;
		phase_w[1] = 13'd3;
		phase_w[2] = 13'd5;
		phase_w[3] = 13'($urandom_range(9, 64));
		phase_w[4] = 13'd4;
		phase_w[5] = 13'd2;
		phase_w[6] = 13'($urandom_range(6, 33));
		phase_w[7] = 13'd4096;

		for (int ph = 0; ph < PHASES; ph++) begin
			set_width(phase_w[ph]);
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 49;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 49;
				end
				default: begin
					idle_pct = 25;
					stall_pct = 25;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long sink hold while pixels keep coming
				if (ph == 0 && i == PHASE_ITEMS / 2) hold_req = 1;
				if ($urandom_range(9) == 0)
					px = $urandom_range(1) ? 8'hFF : 8'h00;
				else
					px = 8'($urandom_range(255));
				send_pixel(px, PREDICT, '0, '0);
			end
		end

		pix_ch.valid <= 1'b0;
		while (reduced_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d pixels sent over %0d row width settings, %0d reduced pixels checked",
			n_in, n_cfg, n_out);
		$display("%0d mismatches, %0d reduced pixels still owed", mismatches,
			reduced_q.size());
		if (mismatches == 0 && reduced_q.size() == 0)
			$display("tb_gauss_reduce_row_5tap: clean");
		else
			$display("tb_gauss_reduce_row_5tap: errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/gr5_pkg.sv
hw/rtl/gr5_pix_if.sv
hw/rtl/gr5_res_if.sv
hw/rtl/gr5_tap_cell.sv
hw/rtl/gr5_div20.sv
hw/rtl/gr5_res_fifo.sv
hw/rtl/gauss_reduce_row_5tap.sv
hw/rtl/gr5_checker.sv
test/tb_gauss_reduce_row_5tap.sv
